FILE: rtl/mvt_pkg.sv
package mvt_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ELEM_BITS = 32;
   localparam int OUT_BITS = 32;
   localparam int OPND_W = (ELEM_BITS > OUT_BITS) ? ELEM_BITS : OUT_BITS;

   localparam logic [ELEM_BITS-1:0] ELEM_MAX = {1'b0, {(ELEM_BITS-1){1'b1}}};
   localparam logic [ELEM_BITS-1:0] ELEM_MIN = {1'b1, {(ELEM_BITS-1){1'b0}}};
   localparam logic [ELEM_BITS-1:0] ELEM_ONE =
      (FRAC_BITS < ELEM_BITS - 1) ? (ELEM_BITS'(1) << FRAC_BITS) : ELEM_MAX;

   localparam logic [2:0] ACT_IDENT = 3'd0;
   localparam logic [2:0] ACT_LOAD  = 3'd1;
   localparam logic [2:0] ACT_MUL   = 3'd2;
   localparam logic [2:0] ACT_XFORM = 3'd3;
   localparam logic [2:0] ACT_READ  = 3'd4;

   localparam logic [1:0] MODE_IDENT = 2'd0;
   localparam logic [1:0] MODE_MUL   = 2'd1;
   localparam logic [1:0] MODE_XFORM = 2'd2;

   typedef struct packed {
      logic [2:0]         action;
      logic [3:0]         elem_index;
      logic signed [31:0] elem_value;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] mode;
      logic [1:0] k;
      logic [1:0] c;
      logic       first;
      logic       last;
   } tag_type;

   typedef struct packed {
      tag_type                   tag;
      logic signed [OPND_W-1:0] opnd;
   } tok_type;

   typedef struct packed {
      logic                       valid;
      logic signed [OUT_BITS-1:0] value;
      logic                       sat;
   } res_type;

   typedef logic [3:0][ELEM_BITS-1:0] row_type;

   function automatic row_type ident_row(input logic [1:0] row_id);
      row_type r;
      for (int j = 0; j < 4; j++) begin
         r[j] = (2'(j) == row_id) ? ELEM_ONE : '0;
      end
      return r;
   endfunction

endpackage

FILE: rtl/mvt_cell.sv
module mvt_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       row_id,
   input  mvt_pkg::tok_type tok_i,
   output mvt_pkg::tok_type tok_o,
   output mvt_pkg::row_type row_o,
   output mvt_pkg::res_type res_o
);
   import mvt_pkg::*;

   localparam int PROD_W = ELEM_BITS + OPND_W;
   localparam int ACC_W = PROD_W + 3;
   localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] A_EMAX =
      {{(ACC_W-ELEM_BITS+1){1'b0}}, {(ELEM_BITS-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] A_EMIN = ~A_EMAX;
   localparam logic signed [ACC_W-1:0] A_OMAX =
      {{(ACC_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] A_OMIN = ~A_OMAX;

   tok_type                  tok_ff, tok_in;
   row_type                  row_ff, row_in, shadow_ff, shadow_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   tag_type                  ptag_ff, ptag_in, dtag_ff, dtag_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, shifted;
   logic [ELEM_BITS-1:0]     elem_val;

   assign tok_in = tok_i;
   assign tok_o = tok_ff;
   assign row_o = row_ff;
   assign shifted = acc_ff >>> FRAC_BITS;

   always_comb begin
      prod_in = PROD_W'($signed(row_ff[tok_ff.tag.k])) * PROD_W'(tok_ff.opnd);
      ptag_in = tok_ff.tag;
      dtag_in = ptag_ff;
      dtag_in.valid = ptag_ff.valid && ptag_ff.last && (ptag_ff.mode != MODE_IDENT);
      acc_in = acc_ff;
      if (ptag_ff.valid && (ptag_ff.mode != MODE_IDENT)) begin
         acc_in = (ptag_ff.first ? RND : acc_ff) + ACC_W'(prod_ff);
      end
      if (shifted > A_EMAX) begin
         elem_val = ELEM_MAX;
      end else if (shifted < A_EMIN) begin
         elem_val = ELEM_MIN;
      end else begin
         elem_val = shifted[ELEM_BITS-1:0];
      end
      res_o.valid = dtag_ff.valid && (dtag_ff.mode == MODE_XFORM);
      res_o.sat = 1'b0;
      if (shifted > A_OMAX) begin
         res_o.value = A_OMAX[OUT_BITS-1:0];
         res_o.sat = 1'b1;
      end else if (shifted < A_OMIN) begin
         res_o.value = A_OMIN[OUT_BITS-1:0];
         res_o.sat = 1'b1;
      end else begin
         res_o.value = shifted[OUT_BITS-1:0];
      end
      row_in = row_ff;
      shadow_in = shadow_ff;
      if (tok_ff.tag.valid && (tok_ff.tag.mode == MODE_IDENT)) begin
         row_in = ident_row(row_id);
      end
      if (dtag_ff.valid && (dtag_ff.mode == MODE_MUL)) begin
         shadow_in[dtag_ff.c] = elem_val;
         if (dtag_ff.c == 2'd3) begin
            row_in = shadow_ff;
            row_in[3] = elem_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.tag <= '0;
         ptag_ff <= '0;
         dtag_ff <= '0;
         row_ff <= ident_row(row_id);
      end else begin
         tok_ff <= tok_in;
         ptag_ff <= ptag_in;
         dtag_ff <= dtag_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      shadow_ff <= shadow_in;
   end

endmodule

FILE: rtl/matrix_vector_transform_4x4.sv
// Channel   Ports                          Moves
// request   req_valid, req_ready, req_data one action per transfer
// response  rsp_valid, rsp_ready, rsp_data one result per transform or read
//
// Load writes its element directly. Read passes through the done state on its way
// to the output register. Identity, transform and multiply follow the
// operand stream that walks down the row cells (one multiplier per row).
// A synchronous reset sets both matrices to identity in the same cycle.
// A new request is accepted while a result waits in the output register.
module matrix_vector_transform_4x4 (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mvt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mvt_pkg::rsp_type rsp_data
);
   import mvt_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_FEED = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;
   localparam logic [3:0] WAIT_LAST = 4'd7;
   localparam logic signed [OPND_W-1:0] O_EMAX =
      {{(OPND_W-ELEM_BITS+1){1'b0}}, {(ELEM_BITS-1){1'b1}}};
   localparam logic signed [OPND_W-1:0] O_EMIN = ~O_EMAX;
   localparam logic signed [OPND_W-1:0] O_OMAX =
      {{(OPND_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
   localparam logic signed [OPND_W-1:0] O_OMIN = ~O_OMAX;

   logic [1:0]                 state_ff, state_in;
   logic [3:0]                 cnt_ff, cnt_in;
   req_type                    req_ff, req_in;
   logic [15:0][ELEM_BITS-1:0] right_ff, right_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;
   logic [2:0][OUT_BITS-1:0]   vres_ff, vres_in;
   logic [2:0]                 vsat_ff, vsat_in;
   tok_type                    chain [5];
   row_type                    rows [4];
   res_type                    res [4];
   logic [3:0]                 last_step;
   logic signed [OPND_W-1:0]   load_ext, read_ext;
   logic [ELEM_BITS-1:0]       load_val;
   logic [OUT_BITS-1:0]        read_val;
   logic                       read_sat;
   logic                       accept;

   for (genvar g = 0; g < 4; g++) begin : g_cell
      mvt_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .row_id (2'(g)),
         .tok_i  (chain[g]),
         .tok_o  (chain[g+1]),
         .row_o  (rows[g]),
         .res_o  (res[g])
      );
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      load_ext = OPND_W'(req_data.elem_value);
      if (load_ext > O_EMAX) begin
         load_val = O_EMAX[ELEM_BITS-1:0];
      end else if (load_ext < O_EMIN) begin
         load_val = O_EMIN[ELEM_BITS-1:0];
      end else begin
         load_val = load_ext[ELEM_BITS-1:0];
      end
      read_ext = OPND_W'($signed(rows[req_ff.elem_index[3:2]][req_ff.elem_index[1:0]]));
      read_sat = 1'b1;
      if (read_ext > O_OMAX) begin
         read_val = O_OMAX[OUT_BITS-1:0];
      end else if (read_ext < O_OMIN) begin
         read_val = O_OMIN[OUT_BITS-1:0];
      end else begin
         read_val = read_ext[OUT_BITS-1:0];
         read_sat = 1'b0;
      end
   end

   always_comb begin
      unique case (req_ff.action)
         ACT_MUL:   last_step = 4'd15;
         ACT_XFORM: last_step = 4'd2;
         default:   last_step = 4'd0;
      endcase
      chain[0] = '0;
      chain[0].tag.valid = (state_ff == S_FEED);
      unique case (req_ff.action)
         ACT_MUL: begin
            chain[0].tag.mode = MODE_MUL;
            chain[0].tag.c = cnt_ff[3:2];
            chain[0].tag.k = cnt_ff[1:0];
            chain[0].opnd = OPND_W'($signed(right_ff[{cnt_ff[1:0], cnt_ff[3:2]}]));
         end
         ACT_XFORM: begin
            chain[0].tag.mode = MODE_XFORM;
            chain[0].tag.k = cnt_ff[1:0];
            unique case (cnt_ff[1:0])
               2'd0:    chain[0].opnd = OPND_W'(req_ff.vec_x);
               2'd1:    chain[0].opnd = OPND_W'(req_ff.vec_y);
               default: chain[0].opnd = OPND_W'(req_ff.vec_z);
            endcase
         end
         default: begin
            chain[0].tag.mode = MODE_IDENT;
         end
      endcase
      chain[0].tag.first = (cnt_ff[1:0] == 2'd0);
      chain[0].tag.last = (cnt_ff[1:0] == last_step[1:0]);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      req_in = req_ff;
      right_in = right_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      vres_in = vres_ff;
      vsat_in = vsat_ff;
      for (int r = 0; r < 3; r++) begin
         if (res[r].valid) begin
            vres_in[r] = res[r].value;
            vsat_in[r] = res[r].sat;
         end
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               cnt_in = '0;
               priority case (req_data.action)
                  ACT_IDENT, ACT_MUL, ACT_XFORM: state_in = S_FEED;
                  ACT_LOAD: right_in[req_data.elem_index] = load_val;
                  ACT_READ: state_in = S_DONE;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FEED: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == last_step) begin
               cnt_in = '0;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == WAIT_LAST) begin
               state_in = (req_ff.action == ACT_XFORM) ? S_DONE : S_IDLE;
            end
         end
         default: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
               if (req_ff.action == ACT_XFORM) begin
                  rsp_in.out_x = vres_ff[0];
                  rsp_in.out_y = vres_ff[1];
                  rsp_in.out_z = vres_ff[2];
                  rsp_in.saturated = |vsat_ff;
               end else begin
                  rsp_in.out_x = read_val;
                  rsp_in.out_y = '0;
                  rsp_in.out_z = '0;
                  rsp_in.saturated = read_sat;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            right_ff[i] <= (i % 5 == 0) ? ELEM_ONE : '0;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         right_ff <= right_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      vres_ff <= vres_in;
      vsat_ff <= vsat_in;
   end

endmodule

FILE: test/tb_matrix_vector_transform_4x4.sv
module tb_matrix_vector_transform_4x4;
   timeunit 1ns;
   timeprecision 1ps;

   import mvt_pkg::*;

   class transform_scoreboard;
      logic signed [31:0] cur_m[16];
      logic signed [31:0] buf_m[16];
      rsp_type results_due[$];
      int errors;
      int checked;

      function new();
         errors = 0;
         checked = 0;
         set_identity(cur_m);
         set_identity(buf_m);
      endfunction

      function void set_identity(ref logic signed [31:0] m[16]);
         for (int i = 0; i < 16; i++) begin
            m[i] = (i % 5 == 0) ? 32'sh0001_0000 : 32'sh0;
         end
      endfunction

      function logic signed [31:0] round_sat(input logic signed [127:0] acc,
                                             ref bit clip);
         logic signed [127:0] s;
         s = (acc + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         if (s > 128'sh7fff_ffff) begin
            clip = 1'b1;
            return 32'sh7fff_ffff;
         end
         if (s < -128'sh8000_0000) begin
            clip = 1'b1;
            return 32'sh8000_0000;
         end
         return s[31:0];
      endfunction

      function void note_request(input req_type r);
         logic signed [31:0] prod[16];
         logic signed [31:0] v[3];
         logic signed [127:0] acc;
         logic signed [31:0] o[3];
         rsp_type e;
         bit clip;
         clip = 1'b0;
         case (r.action)
            ACT_IDENT: set_identity(cur_m);
            ACT_LOAD: buf_m[r.elem_index] = r.elem_value;
            ACT_MUL: begin
               for (int i = 0; i < 4; i++) begin
                  for (int j = 0; j < 4; j++) begin
                     acc = '0;
                     for (int k = 0; k < 4; k++) begin
                        acc += 128'(cur_m[i*4+k]) * 128'(buf_m[k*4+j]);
                     end
                     prod[i*4+j] = round_sat(acc, clip);
                  end
               end
               cur_m = prod;
            end
            ACT_XFORM: begin
               v[0] = r.vec_x;
               v[1] = r.vec_y;
               v[2] = r.vec_z;
               for (int i = 0; i < 3; i++) begin
                  acc = '0;
                  for (int k = 0; k < 3; k++) begin
                     acc += 128'(cur_m[i*4+k]) * 128'(v[k]);
                  end
                  o[i] = round_sat(acc, clip);
               end
               e.out_x = o[0];
               e.out_y = o[1];
               e.out_z = o[2];
               e.saturated = clip;
               results_due.push_back(e);
            end
            ACT_READ: begin
               e.out_x = cur_m[r.elem_index];
               e.out_y = '0;
               e.out_z = '0;
               e.saturated = 1'b0;
               results_due.push_back(e);
            end
            default: ;
         endcase
      endfunction

      function void check_result(input rsp_type got);
         rsp_type e;
         if (results_due.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
         end
         e = results_due.pop_front();
         checked++;
         if (got.out_x !== e.out_x) begin
            $error("out_x expected %h actual %h", e.out_x, got.out_x);
            errors++;
         end
         if (got.out_y !== e.out_y) begin
            $error("out_y expected %h actual %h", e.out_y, got.out_y);
            errors++;
         end
         if (got.out_z !== e.out_z) begin
            $error("out_z expected %h actual %h", e.out_z, got.out_z);
            errors++;
         end
         if (got.saturated !== e.saturated) begin
            $error("saturated expected %b actual %b", e.saturated, got.saturated);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp_data;

   transform_scoreboard board = new();
   int send_idle_pct = 6;
   int recv_idle_pct = 77;
   bit hold_off = 0;
   int quiet_cycles = 0;
   int sent = 0;

   always #5 clock = ~clock;

   matrix_vector_transform_4x4 u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_request(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            board.check_result(rsp_data);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles > 20000) begin
            $display("matrix_vector_transform_4x4 test failed");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(5))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return $signed($urandom_range(32'h3_0000)) - 32'sh1_8000;
         3: return 32'sh0001_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      sent++;
   endtask

   task automatic send_action(input logic [2:0] act, input logic [3:0] idx,
                              input logic signed [31:0] val);
      req_type r;
      r.action = act;
      r.elem_index = idx;
      r.elem_value = val;
      r.vec_x = pick_value();
      r.vec_y = pick_value();
      r.vec_z = pick_value();
      send(r);
   endtask

   task automatic random_items(input int n);
      req_type r;
      int u;
      for (int i = 0; i < n; i++) begin
         u = $urandom_range(99);
         r = '0;
         r.elem_index = 4'($urandom);
         r.elem_value = pick_value();
         r.vec_x = pick_value();
         r.vec_y = pick_value();
         r.vec_z = pick_value();
         if (u < 40) r.action = ACT_XFORM;
         else if (u < 60) r.action = ACT_LOAD;
         else if (u < 75) r.action = ACT_READ;
         else if (u < 83) r.action = ACT_MUL;
         else if (u < 88) r.action = ACT_IDENT;
         else if (u < 91) r.action = 3'($urandom_range(5, 7));
         else begin
            for (int k = 0; k < 16; k++) begin
               send_action(ACT_LOAD, 4'(k), $signed($urandom_range(32'h2_0000)) - 32'sh1_0000);
            end
            r.action = ACT_MUL;
         end
         send(r);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.results_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (40) @(negedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      for (int i = 0; i < 16; i++) begin
         send_action(ACT_READ, 4'(i), 32'sd0);
      end
      send_action(ACT_XFORM, 4'd0, 32'sd0);
      send_action(ACT_LOAD, 4'd0, 32'sh7fff_ffff);
      send_action(ACT_LOAD, 4'd15, 32'sh8000_0000);
      send_action(ACT_MUL, 4'd0, 32'sd0);
      send_action(ACT_READ, 4'd0, 32'sd0);
      send_action(ACT_XFORM, 4'd0, 32'sd0);
      send_action(ACT_MUL, 4'd0, 32'sd0);
      send_action(3'd7, 4'd0, 32'sd0);
      send_action(ACT_IDENT, 4'd0, 32'sd0);
      random_items(150);
      fork
         begin
            hold_off = 1;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         random_items(30);
      join
      send_idle_pct = 77;
      recv_idle_pct = 6;
      random_items(150);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_items(150);
      drain();
      $display("Sent %0d transfers and checked %0d results across identity, load,", sent,
               board.checked);
      $display("multiply, transform, read and unused actions, with stalls on both sides.");
      if (board.errors == 0) begin
         $display("matrix_vector_transform_4x4 test passed");
      end else begin
         $display("matrix_vector_transform_4x4 test failed");
      end
      $finish;
   end
endmodule

FILE: filelist.f
rtl/mvt_pkg.sv
rtl/mvt_cell.sv
rtl/matrix_vector_transform_4x4.sv
test/tb_matrix_vector_transform_4x4.sv
